FILE: design/cfts_pkg.sv
// Shared widths, codes and payload types for the cube map face and texel select block.
// Used by every module of the block and by its checker; depends on nothing.

package cfts_pkg;

  localparam int DIR_W         = 16;
  localparam int MAG_W         = 16;
  localparam int SIZE_W        = 13;
  localparam int TEX_W         = 12;
  localparam int MAX_FACE_SIZE = 4096;
  localparam int NUM_W         = MAG_W + 1;
  localparam int DEN_W         = MAG_W + 1;
  localparam int Q_W           = $clog2(MAX_FACE_SIZE) + 1;
  localparam int PROD_W        = NUM_W + SIZE_W;
  localparam int SEL_LAT       = 2;
  localparam int LANE_LAT      = Q_W + 2;
  localparam int LATENCY       = SEL_LAT + LANE_LAT + 1;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [2:0] FACE_POS_Z = 3'd0;
  localparam logic [2:0] FACE_NEG_Z = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_X = 3'd4;
  localparam logic [2:0] FACE_NEG_X = 3'd5;

  localparam logic REG_FACE_WIDTH  = 1'b0;
  localparam logic REG_FACE_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd128;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } cfts_dir_t;

  typedef struct packed {
    logic [2:0]       face;
    logic [TEX_W-1:0] texel_x;
    logic [TEX_W-1:0] texel_y;
    logic             degenerate;
  } cfts_res_t;

  typedef struct packed {
    logic [2:0]       face;
    logic             degenerate;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [DEN_W-1:0] den;
  } cfts_sel_t;

  typedef struct packed {
    logic [2:0] face;
    logic       degenerate;
  } cfts_side_t;

endpackage

FILE: design/cfts_face_sel.sv
// Face selection front end: major axis pick, minor component routing, numerators.
// Two register stages; depends on cfts_pkg.

module cfts_face_sel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  cfts_pkg::cfts_dir_t  dir_i,
  output logic                 valid_o,
  output cfts_pkg::cfts_sel_t  sel_o
);

  localparam int DW = cfts_pkg::DIR_W;
  localparam int MW = cfts_pkg::MAG_W;
  localparam int NW = cfts_pkg::NUM_W;
  localparam int EW = cfts_pkg::MAG_W + 2;

  logic [MW-1:0]          ax, ay, az;
  logic [2:0]             face_d, face_q;
  logic [MW-1:0]          m_d, m_q;
  logic signed [DW-1:0]   ca_d, ca_q, cb_d, cb_q;
  logic                   nega_d, nega_q, negb_d, negb_q;
  logic                   v1_q, v2_q;
  logic signed [EW-1:0]   numa, numb, ca_ext, cb_ext, m_ext;
  cfts_pkg::cfts_sel_t    sel_d, sel_q;

  always_comb begin
    ax = dir_i.dir_x[DW-1] ? MW'(-dir_i.dir_x) : MW'(dir_i.dir_x);
    ay = dir_i.dir_y[DW-1] ? MW'(-dir_i.dir_y) : MW'(dir_i.dir_y);
    az = dir_i.dir_z[DW-1] ? MW'(-dir_i.dir_z) : MW'(dir_i.dir_z);
    if (ax > ay && ax > az) begin
      face_d = (dir_i.dir_x > 0) ? cfts_pkg::FACE_POS_X : cfts_pkg::FACE_NEG_X;
    end else if (!(ax > ay) && ay > az) begin
      face_d = (dir_i.dir_y > 0) ? cfts_pkg::FACE_POS_Y : cfts_pkg::FACE_NEG_Y;
    end else begin
      face_d = (dir_i.dir_z > 0) ? cfts_pkg::FACE_POS_Z : cfts_pkg::FACE_NEG_Z;
    end
    case (face_d)
      cfts_pkg::FACE_POS_Z: begin
        m_d = az; ca_d = dir_i.dir_x; cb_d = dir_i.dir_y; nega_d = 1'b1; negb_d = 1'b0;
      end
      cfts_pkg::FACE_NEG_Z: begin
        m_d = az; ca_d = dir_i.dir_x; cb_d = dir_i.dir_y; nega_d = 1'b0; negb_d = 1'b0;
      end
      cfts_pkg::FACE_POS_Y: begin
        m_d = ay; ca_d = dir_i.dir_x; cb_d = dir_i.dir_z; nega_d = 1'b0; negb_d = 1'b0;
      end
      cfts_pkg::FACE_NEG_Y: begin
        m_d = ay; ca_d = dir_i.dir_x; cb_d = dir_i.dir_z; nega_d = 1'b0; negb_d = 1'b1;
      end
      cfts_pkg::FACE_POS_X: begin
        m_d = ax; ca_d = dir_i.dir_z; cb_d = dir_i.dir_y; nega_d = 1'b0; negb_d = 1'b0;
      end
      default: begin
        m_d = ax; ca_d = dir_i.dir_z; cb_d = dir_i.dir_y; nega_d = 1'b1; negb_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    face_q <= face_d;
    m_q    <= m_d;
    ca_q   <= ca_d;
    cb_q   <= cb_d;
    nega_q <= nega_d;
    negb_q <= negb_d;
    sel_q  <= sel_d;
  end

  always_comb begin
    m_ext  = EW'($signed({1'b0, m_q}));
    ca_ext = EW'(ca_q);
    cb_ext = EW'(cb_q);
    numa   = nega_q ? (m_ext - ca_ext) : (m_ext + ca_ext);
    numb   = negb_q ? (m_ext - cb_ext) : (m_ext + cb_ext);
    sel_d.face       = face_q;
    sel_d.degenerate = (m_q == '0);
    sel_d.num_x      = numa[EW-1] ? '0 : NW'(numa);
    sel_d.num_y      = numb[EW-1] ? '0 : NW'(numb);
    sel_d.den        = {m_q, 1'b0};
  end

  assign valid_o = v2_q;
  assign sel_o   = sel_q;

endmodule

FILE: design/cfts_lane.sv
// Texel lane: numerator times face size, pipelined restoring divide, saturation.
// One quotient bit per stage; depends on cfts_pkg.

module cfts_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [cfts_pkg::NUM_W-1:0]   num_i,
  input  logic [cfts_pkg::DEN_W-1:0]   den_i,
  input  logic [cfts_pkg::SIZE_W-1:0]  size_i,
  output logic                         valid_o,
  output logic [cfts_pkg::TEX_W-1:0]   texel_o
);

  localparam int PW = cfts_pkg::PROD_W;
  localparam int QW = cfts_pkg::Q_W;
  localparam int DW = cfts_pkg::DEN_W;
  localparam int SW = cfts_pkg::SIZE_W;
  localparam int TW = cfts_pkg::TEX_W;
  localparam int CW = (QW > SW) ? QW : SW;

  logic [PW-1:0] rem_q  [0:QW];
  logic [QW-1:0] quo_q  [0:QW];
  logic [DW-1:0] den_q  [0:QW];
  logic [PW-1:0] trial  [1:QW];
  logic [QW:1]   ge;
  logic [QW+1:0] vld_q;
  logic [TW-1:0] tex_d, tex_q;

  always_comb begin
    for (int s = 1; s <= QW; s++) begin
      trial[s] = PW'(den_q[s-1]) << (QW - s);
      ge[s]    = rem_q[s-1] >= trial[s];
    end
  end

  always_comb begin
    if (CW'(quo_q[QW]) >= CW'(size_i)) begin
      tex_d = TW'(size_i - 1'b1);
    end else begin
      tex_d = TW'(quo_q[QW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= PW'(num_i) * PW'(size_i);
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    for (int s = 1; s <= QW; s++) begin
      rem_q[s] <= ge[s] ? (rem_q[s-1] - trial[s]) : rem_q[s-1];
      quo_q[s] <= {quo_q[s-1][QW-2:0], ge[s]};
      den_q[s] <= den_q[s-1];
    end
    tex_q <= tex_d;
  end

  assign valid_o = vld_q[QW+1];
  assign texel_o = tex_q;

endmodule

FILE: design/cubemap_face_texel_select.sv
// Top level of the cube map face and texel select block: APB registers, lanes, output word.
// Depends on cfts_pkg, cfts_face_sel and cfts_lane.
//
//   port group        dir   handshake           payload
//   command           in    start / busy        dir_i   (cfts_dir_t)
//   result            out   done_o strobe       res_o   (cfts_res_t)
//   configuration     in    APB psel..pready    face_width @0x0, face_height @0x4
//
// One word enters per cycle; busy stays low.
// From start to done_o a word passes two select stages, the multiply, one stage per
// quotient bit of the divider (13), saturation and the output register.
// Reset clears the valid bits and sets both face sizes to 128.
// The receiver cannot stall; done_o holds for exactly one cycle per word.

module cubemap_face_texel_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  cfts_pkg::cfts_dir_t           dir_i,
  output logic                          done_o,
  output cfts_pkg::cfts_res_t           res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfts_pkg::ADDR_W-1:0]   paddr,
  input  logic [cfts_pkg::DATA_W-1:0]   pwdata,
  output logic [cfts_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int SW = cfts_pkg::SIZE_W;
  localparam int LL = cfts_pkg::LANE_LAT;
  localparam int DA = cfts_pkg::DATA_W;

  logic [SW-1:0]          width_q, height_q, width_c, height_c;
  logic                   sel_valid, lx_valid, ly_valid;
  cfts_pkg::cfts_sel_t    sel;
  logic [cfts_pkg::TEX_W-1:0] tex_x, tex_y;
  cfts_pkg::cfts_side_t   side_q [0:LL-1];
  cfts_pkg::cfts_res_t    res_d, res_q;
  logic                   done_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cfts_pkg::SIZE_RESET;
      height_q <= cfts_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        cfts_pkg::REG_FACE_WIDTH:  width_q  <= pwdata[SW-1:0];
        cfts_pkg::REG_FACE_HEIGHT: height_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cfts_pkg::REG_FACE_WIDTH:  prdata = DA'(width_q);
      cfts_pkg::REG_FACE_HEIGHT: prdata = DA'(height_q);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      width_c = SW'(1);
    end else if (width_q > SW'(cfts_pkg::MAX_FACE_SIZE)) begin
      width_c = SW'(cfts_pkg::MAX_FACE_SIZE);
    end else begin
      width_c = width_q;
    end
    if (height_q == '0) begin
      height_c = SW'(1);
    end else if (height_q > SW'(cfts_pkg::MAX_FACE_SIZE)) begin
      height_c = SW'(cfts_pkg::MAX_FACE_SIZE);
    end else begin
      height_c = height_q;
    end
  end

  cfts_face_sel u_face_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .dir_i   (dir_i),
    .valid_o (sel_valid),
    .sel_o   (sel)
  );

  cfts_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .num_i   (sel.num_x),
    .den_i   (sel.den),
    .size_i  (width_c),
    .valid_o (lx_valid),
    .texel_o (tex_x)
  );

  cfts_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .num_i   (sel.num_y),
    .den_i   (sel.den),
    .size_i  (height_c),
    .valid_o (ly_valid),
    .texel_o (tex_y)
  );

  always_ff @(posedge clk_i) begin
    side_q[0].face       <= sel.face;
    side_q[0].degenerate <= sel.degenerate;
    for (int i = 1; i < LL; i++) begin
      side_q[i] <= side_q[i-1];
    end
    res_q <= res_d;
  end

  always_comb begin
    res_d.face       = side_q[LL-1].face;
    res_d.degenerate = side_q[LL-1].degenerate;
    res_d.texel_x    = side_q[LL-1].degenerate ? '0 : tex_x;
    res_d.texel_y    = side_q[LL-1].degenerate ? '0 : tex_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lx_valid && ly_valid;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: design/cfts_checker.sv
// Port-level checker for the cube map face and texel select block, and its bind.
// Depends on cfts_pkg and on the cubemap_face_texel_select port names.

module cfts_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input cfts_pkg::cfts_dir_t  dir_i,
  input logic                 done_o,
  input cfts_pkg::cfts_res_t  res_o
);

  localparam int LAT = cfts_pkg::LATENCY;

  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done_o)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without a matching command word");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.degenerate |->
      res_o.texel_x == '0 && res_o.texel_y == '0 && res_o.face == cfts_pkg::FACE_NEG_Z)
    else $error("degenerate result with nonzero texel or wrong face");

  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(start && !busy && dir_i == '0, LAT) |-> res_o.degenerate)
    else $error("zero direction not flagged degenerate");

endmodule

bind cubemap_face_texel_select cfts_checker u_cfts_checker (.*);

FILE: sim/cubemap_face_texel_select_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cubemap_face_texel_select: directed and random directions,
// APB face size writes and read-back, random sender gaps, results checked against a local model.
// Depends on cfts_pkg and the cubemap_face_texel_select RTL.

module cubemap_face_texel_select_tb;
  import cfts_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  cfts_dir_t           dir_i   = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic                busy;
  logic                done_o;
  cfts_res_t           res_o;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [SIZE_W-1:0]   width_reg  = SIZE_RESET;
  logic [SIZE_W-1:0]   height_reg = SIZE_RESET;
  cfts_res_t           expected_words[$];
  int                  mismatches       = 0;
  int                  dirs_sent        = 0;
  int                  words_checked    = 0;
  int                  degenerate_words = 0;
  int                  size_settings    = 0;
  int                  face_hits[6]     = '{default: 0};
  int                  quiet_left       = 0;
  int                  cycle_count      = 0;

  cubemap_face_texel_select DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .dir_i   (dir_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int effective_size(logic [SIZE_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_FACE_SIZE) return MAX_FACE_SIZE;
    return int'(r);
  endfunction

  function automatic logic [TEX_W-1:0] texel_coord(int m, int c, bit neg, int size);
    longint num;
    longint q;
    num = neg ? longint'(m) - c : longint'(m) + c;
    if (num < 0) num = 0;
    q = (num * size) / (2 * longint'(m));
    if (q >= size) q = size - 1;
    return TEX_W'(q);
  endfunction

  function automatic cfts_res_t predict_texel(cfts_dir_t d);
    cfts_res_t r;
    int dx, dy, dz, ax, ay, az, m, a, b;
    bit neg_a, neg_b;
    dx = $signed(d.dir_x);
    dy = $signed(d.dir_y);
    dz = $signed(d.dir_z);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    if (ax > ay) begin
      if (ax > az) r.face = dx > 0 ? FACE_POS_X : FACE_NEG_X;
      else r.face = dz > 0 ? FACE_POS_Z : FACE_NEG_Z;
    end else if (ay > az) begin
      r.face = dy > 0 ? FACE_POS_Y : FACE_NEG_Y;
    end else begin
      r.face = dz > 0 ? FACE_POS_Z : FACE_NEG_Z;
    end
    neg_a = 1'b0;
    neg_b = 1'b0;
    case (r.face)
      FACE_POS_Z: begin m = az; a = dx; b = dy; neg_a = 1'b1; end
      FACE_NEG_Z: begin m = az; a = dx; b = dy; end
      FACE_POS_Y: begin m = ay; a = dx; b = dz; end
      FACE_NEG_Y: begin m = ay; a = dx; b = dz; neg_b = 1'b1; end
      FACE_POS_X: begin m = ax; a = dz; b = dy; end
      default:    begin m = ax; a = dz; b = dy; neg_a = 1'b1; end
    endcase
    if (m == 0) begin
      r.texel_x    = '0;
      r.texel_y    = '0;
      r.degenerate = 1'b1;
    end else begin
      r.texel_x    = texel_coord(m, a, neg_a, effective_size(width_reg));
      r.texel_y    = texel_coord(m, b, neg_b, effective_size(height_reg));
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    cfts_res_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, res_o);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        face_hits[int'(want.face)]++;
        if (want.degenerate) degenerate_words++;
        report_field("face", want.face, res_o.face);
        report_field("texel_x", want.texel_x, res_o.texel_x);
        report_field("texel_y", want.texel_y, res_o.texel_y);
        report_field("degenerate", want.degenerate, res_o.degenerate);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_dir(cfts_dir_t d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    dir_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_words.push_back(predict_texel(d));
    dirs_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg(logic idx, logic [SIZE_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DATA_W'(want)) begin
      $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
               $time, idx, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_sizes(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    write_reg(REG_FACE_WIDTH, w);
    width_reg = w;
    write_reg(REG_FACE_HEIGHT, h);
    height_reg = h;
    read_reg(REG_FACE_WIDTH, width_reg);
    read_reg(REG_FACE_HEIGHT, height_reg);
    size_settings++;
  endtask

  function automatic cfts_dir_t mk_dir(int x, int y, int z);
    cfts_dir_t d;
    d.dir_x = x[DIR_W-1:0];
    d.dir_y = y[DIR_W-1:0];
    d.dir_z = z[DIR_W-1:0];
    return d;
  endfunction

  function automatic int rand_comp();
    logic [DIR_W-1:0] r;
    r = DIR_W'($urandom);
    return int'($signed(r));
  endfunction

  function automatic int signed_mag(int v);
    if (v == 32768) return -32768;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic int corner_comp();
    int corners[6] = '{-32768, -32767, -1, 0, 1, 32767};
    return corners[$urandom_range(0, 5)];
  endfunction

  function automatic cfts_dir_t rand_dir();
    int c[3];
    int mode, v, k;
    for (int i = 0; i < 3; i++) c[i] = rand_comp();
    mode = $urandom_range(0, 9);
    k = $urandom_range(0, 2);
    case (mode)
      5: c[k] = $urandom_range(0, 1) ? 32767 : -32768;
      6: begin
        v = $urandom_range(0, 32768);
        c[k] = signed_mag(v);
        c[(k + 1) % 3] = signed_mag(v);
        if ($urandom_range(0, 1)) c[(k + 2) % 3] = signed_mag(v);
      end
      7: for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 8)) - 4;
      8: begin
        v = $urandom_range(1, 32768);
        c[k] = signed_mag(v);
        c[(k + 1) % 3] = signed_mag(v);
        c[(k + 2) % 3] = signed_mag($urandom_range(0, v - 1));
      end
      9: for (int i = 0; i < 3; i++) c[i] = corner_comp();
      default: ;
    endcase
    return mk_dir(c[0], c[1], c[2]);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    logic [SIZE_W-1:0] picks[6] = '{13'd0, 13'd1, 13'd2, 13'd4095, 13'd4096, 13'd8191};
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SIZE_W'($urandom_range(1, MAX_FACE_SIZE));
    if (r < 85) return SIZE_W'($urandom_range(MAX_FACE_SIZE + 1, 8191));
    return picks[$urandom_range(0, 5)];
  endfunction

  task automatic test_reset_values();
    read_reg(REG_FACE_WIDTH, SIZE_RESET);
    read_reg(REG_FACE_HEIGHT, SIZE_RESET);
  endtask

  task automatic test_directed_faces();
    send_dir(mk_dir(0, 0, 0));
    send_dir(mk_dir(32767, 0, 0));
    send_dir(mk_dir(-32768, 0, 0));
    send_dir(mk_dir(0, 32767, 0));
    send_dir(mk_dir(0, -32768, 0));
    send_dir(mk_dir(0, 0, 32767));
    send_dir(mk_dir(0, 0, -32768));
    send_dir(mk_dir(-32768, -32768, -32768));
    send_dir(mk_dir(32767, -32768, 32767));
    send_dir(mk_dir(100, 100, 50));
    send_dir(mk_dir(100, -50, -100));
    send_dir(mk_dir(50, 100, -100));
    send_dir(mk_dir(1, 0, 0));
    send_dir(mk_dir(-1, 1, 1));
    send_dir(mk_dir(32767, 32767, -32768));
    send_dir(mk_dir(0, -1, 0));
    send_dir(mk_dir(1000, -1000, 999));
    send_dir(mk_dir(-1000, 999, -1000));
    send_dir(mk_dir(0, 0, -1));
    send_dir(mk_dir(32767, -32767, 32767));
    send_dir(mk_dir(-32768, 32767, -32767));
    wait_drained();
  endtask

  task automatic test_size_extremes();
    logic [SIZE_W-1:0] widths[6]  = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'd8191, 13'd3};
    logic [SIZE_W-1:0] heights[6] = '{13'd8191, 13'd1, 13'd4095, 13'd2, 13'd0, 13'd4096};
    for (int s = 0; s < 6; s++) begin
      set_sizes(widths[s], heights[s]);
      repeat (12) send_dir(rand_dir());
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      set_sizes(pick_size(), pick_size());
      for (int i = 0; i < 75; i++) begin
        if (p == 2 && i == 50) wait_drained();
        send_dir(rand_dir());
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed_faces();
    test_size_extremes();
    test_random_traffic();
    $display("Checked %0d result words from %0d directions over %0d size settings, %0d degenerate.",
             words_checked, dirs_sent, size_settings, degenerate_words);
    $display("Face counts: +z %0d, -z %0d, +y %0d, -y %0d, +x %0d, -x %0d.",
             face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4], face_hits[5]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
